// ===== rtl/c6502eu_pkg.sv =====
package c6502eu_pkg;

  // dense alphabetical operation codes
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
    OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
    OP_BVC = 6'd10, OP_BVS = 6'd11, OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14,
    OP_CLV = 6'd15, OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23, OP_INX = 6'd24,
    OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27, OP_LDY = 6'd28, OP_LSR = 6'd29,
    OP_NOP = 6'd30, OP_ORA = 6'd31, OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34,
    OP_PLP = 6'd35, OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
    OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43, OP_STY = 6'd44,
    OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47, OP_TXA = 6'd48, OP_TXS = 6'd49,
    OP_TYA = 6'd50
  } op_e;

  // status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h24;

  typedef struct packed {
    logic [5:0] opcode;
    logic [7:0] operand;
    logic       acc_mode;
  } in_t;

  typedef struct packed {
    logic [7:0] write_value;
    logic       write_enable;
    logic       branch_taken;
    logic [7:0] accumulator;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] stack_pointer;
    logic [7:0] status;
  } out_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

endpackage

// ===== rtl/cpu6502_execute_unit_core.sv =====
// Executes one decoded 6502 instruction per word against the A, X, Y, SP and
// status registers, binary arithmetic only. An accepted word is held in an input
// register, goes through combinational 8-bit ALU logic and lands in the result
// register together with the updated register file, and one word is taken
// every cycle while the result side keeps up. The register file updates as
// each result is loaded, so the next word always sees the state left by the
// previous one.
// After reset A, X, Y and SP are zero and status is 0x24.
module cpu6502_execute_unit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  c6502eu_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output c6502eu_pkg::out_t  out_data_o
);
  import c6502eu_pkg::*;

  in_t   in_q;
  logic  in_vld_q;
  out_t  out_q;
  logic  out_vld_q;
  regs_t regs_q;
  regs_t regs_d;
  out_t  res_d;
  logic  advance;

  c6502eu_alu u_alu (
    .item_i (in_q),
    .regs_i (regs_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      regs_q    <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'h00, p: STATUS_RESET};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        regs_q    <= regs_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_unused_bit_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.p[FLAG_U])
    else $error("status bit 5 cleared");

  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(regs_q))
    else $error("register file changed without a word advancing");

  a_br_we_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.branch_taken && out_data_o.write_enable))
    else $error("branch and write in one result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule

// ===== rtl/c6502eu_alu.sv =====
module c6502eu_alu (
  input  c6502eu_pkg::in_t   item_i,
  input  c6502eu_pkg::regs_t regs_i,
  output c6502eu_pkg::regs_t regs_o,
  output c6502eu_pkg::out_t  res_o
);
  import c6502eu_pkg::*;

  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r         = p;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  logic [7:0] m;
  logic [7:0] add_m;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_in;
  logic [7:0] sh_out;
  logic       sh_c;
  logic [7:0] wv;
  logic       we;
  logic       br;
  regs_t      nxt;
  op_e        op;

  assign op = op_e'(item_i.opcode);
  assign m  = item_i.operand;

  // shared adder for adc and sbc
  assign add_m = (op == OP_SBC) ? ~m : m;
  assign sum   = {1'b0, regs_i.a} + {1'b0, add_m} + {8'h00, regs_i.p[FLAG_C]};

  // shared subtractor for compares
  always_comb begin
    case (op)
      OP_CPX:  cmp_reg = regs_i.x;
      OP_CPY:  cmp_reg = regs_i.y;
      default: cmp_reg = regs_i.a;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, m};

  // shifter
  assign sh_in = item_i.acc_mode ? regs_i.a : m;
  always_comb begin
    case (op)
      OP_ASL: begin
        sh_c   = sh_in[7];
        sh_out = {sh_in[6:0], 1'b0};
      end
      OP_ROL: begin
        sh_c   = sh_in[7];
        sh_out = {sh_in[6:0], regs_i.p[FLAG_C]};
      end
      OP_LSR: begin
        sh_c   = sh_in[0];
        sh_out = {1'b0, sh_in[7:1]};
      end
      default: begin
        sh_c   = sh_in[0];
        sh_out = {regs_i.p[FLAG_C], sh_in[7:1]};
      end
    endcase
  end

  always_comb begin
    nxt = regs_i;
    wv  = 8'h00;
    we  = 1'b0;
    br  = 1'b0;
    case (op)
      OP_ADC, OP_SBC: begin
        nxt.a         = sum[7:0];
        nxt.p[FLAG_C] = sum[8];
        nxt.p[FLAG_V] = (regs_i.a[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
        nxt.p         = set_zn(nxt.p, sum[7:0]);
      end
      OP_AND: begin
        nxt.a = regs_i.a & m;
        nxt.p = set_zn(regs_i.p, regs_i.a & m);
      end
      OP_EOR: begin
        nxt.a = regs_i.a ^ m;
        nxt.p = set_zn(regs_i.p, regs_i.a ^ m);
      end
      OP_ORA: begin
        nxt.a = regs_i.a | m;
        nxt.p = set_zn(regs_i.p, regs_i.a | m);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.p         = set_zn(regs_i.p, sh_out);
        nxt.p[FLAG_C] = sh_c;
        if (item_i.acc_mode) begin
          nxt.a = sh_out;
        end else begin
          wv = sh_out;
          we = 1'b1;
        end
      end
      OP_BCC: br = ~regs_i.p[FLAG_C];
      OP_BCS: br = regs_i.p[FLAG_C];
      OP_BEQ: br = regs_i.p[FLAG_Z];
      OP_BNE: br = ~regs_i.p[FLAG_Z];
      OP_BMI: br = regs_i.p[FLAG_N];
      OP_BPL: br = ~regs_i.p[FLAG_N];
      OP_BVS: br = regs_i.p[FLAG_V];
      OP_BVC: br = ~regs_i.p[FLAG_V];
      OP_BIT: begin
        nxt.p      = set_zn(regs_i.p, regs_i.a & m);
        nxt.p[7:6] = m[7:6];
      end
      OP_CLC: nxt.p[FLAG_C] = 1'b0;
      OP_CLD: nxt.p[FLAG_D] = 1'b0;
      OP_CLI: nxt.p[FLAG_I] = 1'b0;
      OP_CLV: nxt.p[FLAG_V] = 1'b0;
      OP_SEC: nxt.p[FLAG_C] = 1'b1;
      OP_SED: nxt.p[FLAG_D] = 1'b1;
      OP_SEI: nxt.p[FLAG_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.p         = set_zn(regs_i.p, diff[7:0]);
        nxt.p[FLAG_C] = ~diff[8];
      end
      OP_DEC: begin
        wv    = m - 8'd1;
        we    = 1'b1;
        nxt.p = set_zn(regs_i.p, m - 8'd1);
      end
      OP_INC: begin
        wv    = m + 8'd1;
        we    = 1'b1;
        nxt.p = set_zn(regs_i.p, m + 8'd1);
      end
      OP_DEX: begin
        nxt.x = regs_i.x - 8'd1;
        nxt.p = set_zn(regs_i.p, regs_i.x - 8'd1);
      end
      OP_DEY: begin
        nxt.y = regs_i.y - 8'd1;
        nxt.p = set_zn(regs_i.p, regs_i.y - 8'd1);
      end
      OP_INX: begin
        nxt.x = regs_i.x + 8'd1;
        nxt.p = set_zn(regs_i.p, regs_i.x + 8'd1);
      end
      OP_INY: begin
        nxt.y = regs_i.y + 8'd1;
        nxt.p = set_zn(regs_i.p, regs_i.y + 8'd1);
      end
      OP_LDA, OP_PLA: begin
        nxt.a = m;
        nxt.p = set_zn(regs_i.p, m);
        if (op == OP_PLA) begin
          nxt.sp = regs_i.sp + 8'd1;
        end
      end
      OP_LDX: begin
        nxt.x = m;
        nxt.p = set_zn(regs_i.p, m);
      end
      OP_LDY: begin
        nxt.y = m;
        nxt.p = set_zn(regs_i.p, m);
      end
      OP_PHA: begin
        wv     = regs_i.a;
        we     = 1'b1;
        nxt.sp = regs_i.sp - 8'd1;
      end
      OP_PHP: begin
        wv         = regs_i.p;
        wv[FLAG_B] = 1'b1;
        wv[FLAG_U] = 1'b1;
        we         = 1'b1;
        nxt.sp     = regs_i.sp - 8'd1;
      end
      OP_PLP: begin
        nxt.sp        = regs_i.sp + 8'd1;
        nxt.p         = m;
        nxt.p[FLAG_B] = 1'b0;
        nxt.p[FLAG_U] = 1'b1;
      end
      OP_STA: begin
        wv = regs_i.a;
        we = 1'b1;
      end
      OP_STX: begin
        wv = regs_i.x;
        we = 1'b1;
      end
      OP_STY: begin
        wv = regs_i.y;
        we = 1'b1;
      end
      OP_TAX: begin
        nxt.x = regs_i.a;
        nxt.p = set_zn(regs_i.p, regs_i.a);
      end
      OP_TAY: begin
        nxt.y = regs_i.a;
        nxt.p = set_zn(regs_i.p, regs_i.a);
      end
      OP_TSX: begin
        nxt.x = regs_i.sp;
        nxt.p = set_zn(regs_i.p, regs_i.sp);
      end
      OP_TXA: begin
        nxt.a = regs_i.x;
        nxt.p = set_zn(regs_i.p, regs_i.x);
      end
      OP_TXS: nxt.sp = regs_i.x;
      OP_TYA: begin
        nxt.a = regs_i.y;
        nxt.p = set_zn(regs_i.p, regs_i.y);
      end
      default: ;
    endcase
  end

  assign regs_o = nxt;

  always_comb begin
    res_o.write_value   = wv;
    res_o.write_enable  = we;
    res_o.branch_taken  = br;
    res_o.accumulator   = nxt.a;
    res_o.index_x       = nxt.x;
    res_o.index_y       = nxt.y;
    res_o.stack_pointer = nxt.sp;
    res_o.status        = nxt.p;
  end

endmodule

// ===== tb/tb_cpu6502_execute_unit_core.sv =====
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit_core;
  import c6502eu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_WORDS = 270;
  localparam int unsigned HOLD_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  cpu6502_execute_unit_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // architectural registers as the testbench sees them
  logic [7:0] a_q = 8'h00;
  logic [7:0] x_q = 8'h00;
  logic [7:0] y_q = 8'h00;
  logic [7:0] sp_q = 8'h00;
  logic [7:0] p_q = STATUS_RESET;

  out_t        reg_file_q[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  function automatic void set_zn(input logic [7:0] v);
    p_q[FLAG_Z] = (v == 8'h00);
    p_q[FLAG_N] = v[7];
  endfunction

  function automatic void compare_flags(input logic [7:0] lhs, input logic [7:0] m);
    p_q[FLAG_C] = (lhs >= m);
    set_zn(lhs - m);
  endfunction

  function automatic out_t execute_op(input in_t w);
    out_t       r;
    logic [7:0] m;
    logic [7:0] v;
    logic [7:0] s;
    logic [8:0] sum;
    logic       cin;
    op_e        op;
    r = '0;
    m = w.operand;
    s = p_q;
    cin = p_q[FLAG_C];
    op = op_e'(w.opcode);
    case (op)
      OP_ADC, OP_SBC: begin
        if (op == OP_SBC) m = ~m;
        sum = {1'b0, a_q} + {1'b0, m} + {8'd0, cin};
        p_q[FLAG_C] = sum[8];
        p_q[FLAG_V] = (a_q[7] ^ sum[7]) & (m[7] ^ sum[7]);
        a_q = sum[7:0];
        set_zn(a_q);
      end
      OP_AND: begin
        a_q = a_q & m;
        set_zn(a_q);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        v = w.acc_mode ? a_q : m;
        case (op)
          OP_ASL: begin
            p_q[FLAG_C] = v[7];
            v = {v[6:0], 1'b0};
          end
          OP_ROL: begin
            p_q[FLAG_C] = v[7];
            v = {v[6:0], cin};
          end
          OP_LSR: begin
            p_q[FLAG_C] = v[0];
            v = {1'b0, v[7:1]};
          end
          default: begin
            p_q[FLAG_C] = v[0];
            v = {cin, v[7:1]};
          end
        endcase
        set_zn(v);
        if (w.acc_mode) begin
          a_q = v;
        end else begin
          r.write_value = v;
          r.write_enable = 1'b1;
        end
      end
      OP_BCC: r.branch_taken = !s[FLAG_C];
      OP_BCS: r.branch_taken = s[FLAG_C];
      OP_BEQ: r.branch_taken = s[FLAG_Z];
      OP_BNE: r.branch_taken = !s[FLAG_Z];
      OP_BMI: r.branch_taken = s[FLAG_N];
      OP_BPL: r.branch_taken = !s[FLAG_N];
      OP_BVC: r.branch_taken = !s[FLAG_V];
      OP_BVS: r.branch_taken = s[FLAG_V];
      OP_BIT: begin
        set_zn(a_q & m);
        p_q[FLAG_N] = m[7];
        p_q[FLAG_V] = m[6];
      end
      OP_CLC: p_q[FLAG_C] = 1'b0;
      OP_CLD: p_q[FLAG_D] = 1'b0;
      OP_CLI: p_q[FLAG_I] = 1'b0;
      OP_CLV: p_q[FLAG_V] = 1'b0;
      OP_SEC: p_q[FLAG_C] = 1'b1;
      OP_SED: p_q[FLAG_D] = 1'b1;
      OP_SEI: p_q[FLAG_I] = 1'b1;
      OP_CMP: compare_flags(a_q, m);
      OP_CPX: compare_flags(x_q, m);
      OP_CPY: compare_flags(y_q, m);
      OP_DEC, OP_INC: begin
        r.write_value = (op == OP_DEC) ? m - 8'd1 : m + 8'd1;
        r.write_enable = 1'b1;
        set_zn(r.write_value);
      end
      OP_DEX: begin
        x_q = x_q - 8'd1;
        set_zn(x_q);
      end
      OP_DEY: begin
        y_q = y_q - 8'd1;
        set_zn(y_q);
      end
      OP_INX: begin
        x_q = x_q + 8'd1;
        set_zn(x_q);
      end
      OP_INY: begin
        y_q = y_q + 8'd1;
        set_zn(y_q);
      end
      OP_EOR: begin
        a_q = a_q ^ m;
        set_zn(a_q);
      end
      OP_ORA: begin
        a_q = a_q | m;
        set_zn(a_q);
      end
      OP_LDA: begin
        a_q = m;
        set_zn(m);
      end
      OP_LDX: begin
        x_q = m;
        set_zn(m);
      end
      OP_LDY: begin
        y_q = m;
        set_zn(m);
      end
      OP_PHA: begin
        r.write_value = a_q;
        r.write_enable = 1'b1;
        sp_q = sp_q - 8'd1;
      end
      OP_PHP: begin
        v = s;
        v[FLAG_B] = 1'b1;
        v[FLAG_U] = 1'b1;
        r.write_value = v;
        r.write_enable = 1'b1;
        sp_q = sp_q - 8'd1;
      end
      OP_PLA: begin
        sp_q = sp_q + 8'd1;
        a_q = m;
        set_zn(m);
      end
      OP_PLP: begin
        sp_q = sp_q + 8'd1;
        p_q = m;
        p_q[FLAG_B] = 1'b0;
        p_q[FLAG_U] = 1'b1;
      end
      OP_STA: begin
        r.write_value = a_q;
        r.write_enable = 1'b1;
      end
      OP_STX: begin
        r.write_value = x_q;
        r.write_enable = 1'b1;
      end
      OP_STY: begin
        r.write_value = y_q;
        r.write_enable = 1'b1;
      end
      OP_TAX: begin
        x_q = a_q;
        set_zn(x_q);
      end
      OP_TAY: begin
        y_q = a_q;
        set_zn(y_q);
      end
      OP_TSX: begin
        x_q = sp_q;
        set_zn(x_q);
      end
      OP_TXA: begin
        a_q = x_q;
        set_zn(a_q);
      end
      OP_TXS: sp_q = x_q;
      OP_TYA: begin
        a_q = y_q;
        set_zn(a_q);
      end
      default: ;
    endcase
    r.accumulator = a_q;
    r.index_x = x_q;
    r.index_y = y_q;
    r.stack_pointer = sp_q;
    r.status = p_q;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] edges[6];
    edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [5:0] opcode, input logic [7:0] operand,
                           input logic acc);
    in_t w;
    int  gap;
    w.opcode = opcode;
    w.operand = operand;
    w.acc_mode = acc;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    reg_file_q.push_back(execute_op(w));
  endtask

  task automatic test_corner_cases();
    send_word(OP_PHA, 8'h00, 1'b0);
    send_word(OP_PLP, 8'hFF, 1'b0);
    send_word(OP_PHP, 8'h00, 1'b0);
    send_word(OP_PLA, 8'h80, 1'b0);
    send_word(OP_CLD, 8'h00, 1'b0);
    send_word(OP_CLC, 8'h00, 1'b0);
    send_word(OP_LDA, 8'h7F, 1'b0);
    send_word(OP_ADC, 8'h01, 1'b0);
    send_word(OP_ADC, 8'hFF, 1'b0);
    send_word(OP_SBC, 8'h7F, 1'b0);
    send_word(OP_SED, 8'h00, 1'b0);
    send_word(OP_ADC, 8'h09, 1'b0);
    send_word(OP_CMP, 8'hFF, 1'b0);
    send_word(OP_LDX, 8'hFF, 1'b0);
    send_word(OP_INX, 8'h00, 1'b0);
    send_word(OP_CPX, 8'h00, 1'b0);
    send_word(OP_DEY, 8'h00, 1'b0);
    send_word(OP_TXS, 8'h00, 1'b0);
    send_word(OP_TSX, 8'h00, 1'b0);
    send_word(OP_SEC, 8'h00, 1'b0);
    send_word(OP_ROL, 8'h80, 1'b0);
    send_word(OP_ROR, 8'h00, 1'b1);
    send_word(OP_LSR, 8'h01, 1'b0);
    send_word(OP_ASL, 8'h00, 1'b1);
    send_word(OP_BIT, 8'hC0, 1'b0);
    send_word(OP_LDA, 8'h00, 1'b1);
    send_word(OP_INC, 8'hFF, 1'b0);
    send_word(OP_DEC, 8'h00, 1'b0);
    send_word(6'd63, 8'hFF, 1'b1);
  endtask

  task automatic test_every_opcode();
    for (int c = 0; c < 64; c++) begin
      send_word(c[5:0], rand_byte(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_word(6'($urandom_range(0, 50)), rand_byte(), 1'($urandom_range(0, 1)));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_programs();
    int unsigned n;
    int unsigned kind;
    n = 0;
    while (n < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_word(6'($urandom_range(0, 50)), rand_byte(), 1'($urandom_range(0, 1)));
        n += 1;
      end else if (kind == 7) begin
        send_word(6'($urandom_range(51, 63)), rand_byte(), 1'($urandom_range(0, 1)));
        n += 1;
      end else if (kind == 8) begin
        // load, arithmetic, compare, then a branch (or BIT) on the result
        send_word(OP_LDA, rand_byte(), 1'b0);
        send_word($urandom_range(0, 1) ? OP_ADC : OP_SBC, rand_byte(), 1'b0);
        send_word(6'($urandom_range(OP_CMP, OP_CPY)), rand_byte(), 1'b0);
        send_word(6'($urandom_range(OP_BCC, OP_BVS)), rand_byte(), 1'b0);
        n += 4;
      end else begin
        // stack round trip through X and SP
        send_word(OP_LDX, rand_byte(), 1'b0);
        send_word(OP_TXS, rand_byte(), 1'b0);
        send_word($urandom_range(0, 1) ? OP_PHA : OP_PHP, rand_byte(), 1'b0);
        send_word($urandom_range(0, 1) ? OP_PLA : OP_PLP, rand_byte(), 1'b0);
        send_word(OP_TSX, rand_byte(), 1'b0);
        n += 5;
      end
    end
  endtask

  initial begin : sink
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned tick;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        mode = $urandom_range(0, 2);
      end
      seg_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 99) >= 35);
          default: out_ready_i <= (tick % 4 == 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (reg_file_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        exp_w = reg_file_q.pop_front();
        check_field("write_value", exp_w.write_value, out_data_o.write_value);
        check_field("write_enable", 8'(exp_w.write_enable), 8'(out_data_o.write_enable));
        check_field("branch_taken", 8'(exp_w.branch_taken), 8'(out_data_o.branch_taken));
        check_field("accumulator", exp_w.accumulator, out_data_o.accumulator);
        check_field("index_x", exp_w.index_x, out_data_o.index_x);
        check_field("index_y", exp_w.index_y, out_data_o.index_y);
        check_field("stack_pointer", exp_w.stack_pointer, out_data_o.stack_pointer);
        check_field("status", exp_w.status, out_data_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_every_opcode();
    test_backpressure();
    test_random_programs();
    in_valid_i <= 1'b0;
    while (reg_file_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
